@@ design/qphs_pkg.sv @@
// Shared types and constants for the quadratic-probing hash set.
package qphs_pkg;

    localparam int CFG_W  = 11;
    localparam int STAT_W = 3;
    localparam int SLOT_W = 10;
    localparam int CNT_W  = 11;

    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STAT_W-1:0] ST_ABSENT    = 3'd4;

    localparam logic CFG_TABLE_SIZE = 1'b0;
    localparam logic CFG_LOAD_LIMIT = 1'b1;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 11'd1021;
    localparam logic [CFG_W-1:0] LOAD_LIMIT_RESET = 11'd512;
    localparam logic [CNT_W-1:0] COUNT_MAX        = 11'd2047;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture request, start the modulo
        logic mod_step;  // one restoring-division step
        logic cmp;       // evaluate read data, advance probe
        logic wr;        // write key into current slot
        logic clr;       // clearing pass write
        logic fin;       // build result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic key_zero;
        logic mod_done;
        logic hit_end;   // probe loop terminates
        logic do_write;  // termination is an insert into an empty slot
        logic clr_done;
    } t_sts;

endpackage

@@ design/qphs_ram.sv @@
// Generic single-port RAM with registered read.
module qphs_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/qphs_ctrl.sv @@
// Controller state machine of the hash set.
module qphs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  qphs_pkg::t_sts  i_sts,
    output qphs_pkg::t_cmd  o_cmd
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_MOD, S_READ, S_WAIT, S_CMP, S_WRITE, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (i_sts.key_zero) begin
                    n_state = S_OUT;
                end else if (i_sts.mod_done) begin
                    n_state = S_READ;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_READ: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_sts.hit_end) begin
                    n_state = i_sts.do_write ? S_WRITE : S_OUT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_WRITE: begin
                o_cmd.wr = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

@@ design/qphs_dp.sv @@
// Datapath of the hash set: modulo unit, probe walk, slot memory and result registers.
module qphs_dp #(
    parameter int DEPTH    = 1024,
    parameter int KEY_BITS = 31
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  qphs_pkg::t_cmd              i_cmd,
    output qphs_pkg::t_sts              o_sts,
    input  logic                        i_op,
    input  logic [KEY_BITS-1:0]         i_key,
    input  logic [qphs_pkg::CFG_W-1:0]  i_table_size,
    input  logic [qphs_pkg::CFG_W-1:0]  i_load_limit,
    output logic [qphs_pkg::STAT_W-1:0] o_status,
    output logic [qphs_pkg::SLOT_W-1:0] o_slot,
    output logic [qphs_pkg::CNT_W-1:0]  o_probe_count,
    output logic [qphs_pkg::CNT_W-1:0]  o_key_count,
    output logic                        o_over_load
);
    localparam int AW = $clog2(DEPTH);
    localparam int SW = AW + 1;            // holds DEPTH itself
    localparam int KB = KEY_BITS;
    localparam int DBITS = $clog2(KB + 1);

    // Active size, clamped to [2, DEPTH].
    logic [SW-1:0] w_size;
    always_comb begin
        if (i_table_size < qphs_pkg::CFG_W'(2)) begin
            w_size = SW'(2);
        end else if (32'(i_table_size) > 32'(DEPTH)) begin
            w_size = SW'(DEPTH);
        end else begin
            w_size = SW'(i_table_size);
        end
    end

    logic                r_op;
    logic [KB-1:0]       r_key;
    logic [SW-1:0]       r_size;
    logic [SW:0]         r_rem;            // partial remainder
    logic [DBITS-1:0]    r_bit;            // division steps left
    logic [AW-1:0]       r_idx, r_first;
    logic [SW:0]         r_step;           // 2i+1 mod size
    logic [SW-1:0]       r_i;              // probe number
    logic [qphs_pkg::STAT_W-1:0] r_stat;
    logic [AW-1:0]       r_hit;
    logic [qphs_pkg::CNT_W-1:0]  r_keys;
    logic [AW:0]         r_clr;
    logic [qphs_pkg::STAT_W-1:0] r_o_stat;
    logic [qphs_pkg::SLOT_W-1:0] r_o_slot;
    logic [qphs_pkg::CNT_W-1:0]  r_o_probe, r_o_keys;
    logic                r_o_over;

    logic [KB-1:0] w_rdata;
    logic          w_we;
    logic [AW-1:0] w_addr;
    logic [KB-1:0] w_wdata;

    // Restoring division: one key bit per step.
    logic [SW+1:0] w_shift;
    logic [SW+1:0] w_sub;
    always_comb begin
        w_shift = {r_rem, r_key[r_bit - DBITS'(1)]};
        w_sub   = w_shift - (SW+2)'(r_size);
    end

    // Probe advance: idx += 2i+1, step += 2, both mod size.
    logic [SW+1:0] w_nidx, w_nstep;
    logic          w_last, w_wrap, w_match, w_empty, w_end;
    always_comb begin
        w_nidx  = (SW+2)'(r_idx) + (SW+2)'(r_step);
        if (w_nidx >= (SW+2)'(r_size)) begin
            w_nidx = w_nidx - (SW+2)'(r_size);
        end
        w_nstep = (SW+2)'(r_step) + (SW+2)'(2);
        if (w_nstep >= (SW+2)'(r_size)) begin
            w_nstep = w_nstep - (SW+2)'(r_size);
        end
        w_wrap  = (r_i != '0) && (r_idx == r_first);
        w_match = (w_rdata == r_key);
        w_empty = (w_rdata == '0);
        w_last  = (r_i + SW'(1) == r_size);
        w_end   = w_wrap || w_match || w_empty || w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys    <= '0;
            r_clr     <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + (AW+1)'(1);
            end
            if (i_cmd.load) begin
                r_op   <= i_op;
                r_key  <= i_key;
                r_size <= w_size;
                r_rem  <= '0;
                r_bit  <= DBITS'(KB);
                r_i    <= '0;
                r_step <= (SW+1)'(1);
                r_stat <= i_op ? qphs_pkg::ST_ABSENT : qphs_pkg::ST_FULL;
                r_hit  <= '0;
            end
            if (i_cmd.mod_step) begin
                r_rem <= w_sub[SW+1] ? w_shift[SW:0] : w_sub[SW:0];
                r_bit <= r_bit - DBITS'(1);
                if (r_bit == DBITS'(1)) begin
                    r_idx   <= AW'(w_sub[SW+1] ? w_shift[SW:0] : w_sub[SW:0]);
                    r_first <= AW'(w_sub[SW+1] ? w_shift[SW:0] : w_sub[SW:0]);
                end
            end
            if (i_cmd.cmp) begin
                if (w_wrap) begin
                    r_stat <= r_op ? qphs_pkg::ST_ABSENT : qphs_pkg::ST_FULL;
                end else if (w_match) begin
                    r_stat <= r_op ? qphs_pkg::ST_FOUND : qphs_pkg::ST_DUPLICATE;
                    r_hit  <= r_op ? r_idx : '0;
                end else if (w_empty) begin
                    r_stat <= r_op ? qphs_pkg::ST_ABSENT : qphs_pkg::ST_INSERTED;
                    r_hit  <= r_op ? '0 : r_idx;
                end
                if (!w_end) begin
                    r_i    <= r_i + SW'(1);
                    r_idx  <= AW'(w_nidx);
                    r_step <= (SW+1)'(w_nstep);
                end
            end
            if (i_cmd.wr && r_keys != qphs_pkg::COUNT_MAX) begin
                r_keys <= r_keys + qphs_pkg::CNT_W'(1);
            end
            if (i_cmd.fin) begin
                r_o_stat  <= (r_key == '0)
                           ? (r_op ? qphs_pkg::ST_ABSENT : qphs_pkg::ST_FULL) : r_stat;
                r_o_slot  <= (r_key == '0) ? '0 : qphs_pkg::SLOT_W'(r_hit);
                r_o_probe <= (r_key == '0) ? qphs_pkg::CNT_W'(1)
                                           : qphs_pkg::CNT_W'(r_i + SW'(1));
                r_o_keys  <= r_keys;
                r_o_over  <= (r_keys > i_load_limit);
            end
        end
    end

    always_comb begin
        w_we    = i_cmd.clr || i_cmd.wr;
        w_addr  = i_cmd.clr ? r_clr[AW-1:0] : r_idx;
        w_wdata = i_cmd.clr ? '0 : r_key;
    end

    qphs_ram #(.WIDTH(KB), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign o_sts.key_zero = (r_key == '0);
    assign o_sts.mod_done = (r_bit == '0);
    assign o_sts.hit_end  = w_end;
    assign o_sts.do_write = w_empty && !w_wrap && !w_match && !r_op;
    assign o_sts.clr_done = (r_clr == (AW+1)'(DEPTH - 1));

    assign o_status      = r_o_stat;
    assign o_slot        = r_o_slot;
    assign o_probe_count = r_o_probe;
    assign o_key_count   = r_o_keys;
    assign o_over_load   = r_o_over;
endmodule

@@ design/quadratic_probe_hash_set.sv @@
// Top level of the quadratic-probing hash set.
// A request with a nonzero key runs the modulo, one division step per key bit, then for
// each probe a read, a wait for the registered read data and a compare; an insert adds
// a write, and the result is then presented. One request is taken at a time; the probe
// walk runs through the single slot memory port. After reset a clearing pass empties
// every slot of the memory, during which no request is taken.
module quadratic_probe_hash_set #(
    parameter int DEPTH    = 1024,
    parameter int KEY_BITS = 31
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_op,
    input  logic [KEY_BITS-1:0]         i_key,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [qphs_pkg::STAT_W-1:0] o_status,
    output logic [qphs_pkg::SLOT_W-1:0] o_slot,
    output logic [qphs_pkg::CNT_W-1:0]  o_probe_count,
    output logic [qphs_pkg::CNT_W-1:0]  o_key_count,
    output logic                        o_over_load,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [qphs_pkg::CFG_W-1:0]  i_cfg_data
);
    // Configuration registers; writes must arrive only while the block is idle, as the block does not enforce it.
    logic [qphs_pkg::CFG_W-1:0] r_table_size, r_load_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= qphs_pkg::TABLE_SIZE_RESET;
            r_load_limit <= qphs_pkg::LOAD_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                qphs_pkg::CFG_TABLE_SIZE: r_table_size <= i_cfg_data;
                qphs_pkg::CFG_LOAD_LIMIT: r_load_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    qphs_pkg::t_cmd w_cmd;
    qphs_pkg::t_sts w_sts;

    // The controller sequences each request: modulo, probe loop, write, result.
    qphs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the slot memory, the key count and the result registers.
    qphs_dp #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_table_size  (r_table_size),
        .i_load_limit  (r_load_limit),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_probe_count (o_probe_count),
        .o_key_count   (o_key_count),
        .o_over_load   (o_over_load)
    );
endmodule
